FILE: rtl/gaussian_blur_5x5_renormalized_defines.svh
// Assertion macros for the blur block.
`ifndef GAUSSIAN_BLUR_5X5_RENORMALIZED_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RENORMALIZED_DEFINES_SVH
`ifndef ASSERT_OFF
`define GBR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("blur assertion failed");
`define GBR_ASSERT_NEXT(lbl, clk, rst, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("blur assertion failed");
`else
`define GBR_ASSERT(lbl, clk, rst, prop)
`define GBR_ASSERT_NEXT(lbl, clk, rst, trig, prop)
`endif
`endif

FILE: rtl/gbr_pkg.sv
package gbr_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int IMG_W_W       = 12;
  localparam int IMG_H_W       = 13;
  localparam int CNT_W         = 25;
  localparam int PIX_W         = 32;
  localparam int CHAN_W        = 8;
  localparam int LANES         = 4;
  localparam int WT_W          = 6;
  localparam int WSUM_W        = 8;
  localparam int ACC_W         = 16;
  localparam int DIV_STEPS     = 16;
  localparam int DIV_CNT_W     = 4;
  localparam int TAP_W         = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET   = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] IMG_H_RESET   = IMG_H_W'(480);
  localparam logic [TAP_W-1:0]   TAP_LAST      = TAP_W'(4);
  localparam logic [WSUM_W-1:0]  CENTER_WEIGHT = WSUM_W'(49);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_FLUSH,
    ST_DIVIDE,
    ST_DONE
  } gbr_state_t;

  typedef struct packed {
    logic clear;
    logic accumulate;
    logic div_step;
  } lane_ctl_t;

  function automatic logic [WT_W-1:0] kernel_weight(input logic [TAP_W-1:0] dy,
                                                     input logic [TAP_W-1:0] dx);
    logic [1:0] ky;
    logic [1:0] kx;
    logic [WT_W-1:0] wt;
    ky = (dy > TAP_W'(2)) ? 2'(TAP_W'(4) - dy) : dy[1:0];
    kx = (dx > TAP_W'(2)) ? 2'(TAP_W'(4) - dx) : dx[1:0];
    case ({ky, kx})
      4'b0000: wt = WT_W'(1);
      4'b0001: wt = WT_W'(4);
      4'b0010: wt = WT_W'(8);
      4'b0100: wt = WT_W'(4);
      4'b0101: wt = WT_W'(12);
      4'b0110: wt = WT_W'(15);
      4'b1000: wt = WT_W'(8);
      4'b1001: wt = WT_W'(25);
      4'b1010: wt = WT_W'(49);
      default: wt = '0;
    endcase
    return wt;
  endfunction

endpackage

FILE: rtl/gbr_lane.sv
module gbr_lane import gbr_pkg::*; (
  input  logic              clk,
  input  lane_ctl_t         ctl,
  input  logic [WT_W-1:0]   weight,
  input  logic [CHAN_W-1:0] sample,
  input  logic [WSUM_W-1:0] wsum,
  output logic [CHAN_W-1:0] quotient
);

  logic [ACC_W-1:0]  acc;
  logic [WSUM_W-1:0] rem;
  logic [WSUM_W:0]   trial;
  logic [ACC_W-1:0]  product;

  assign product  = ACC_W'(weight) * ACC_W'(sample);
  assign trial    = {rem, acc[ACC_W-1]};
  assign quotient = acc[CHAN_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
      rem <= '0;
    end else if (ctl.accumulate) begin
      acc <= acc + product;
    end else if (ctl.div_step) begin
      if (trial >= {1'b0, wsum}) begin
        rem <= WSUM_W'(trial - {1'b0, wsum});
        acc <= {acc[ACC_W-2:0], 1'b1};
      end else begin
        rem <= trial[WSUM_W-1:0];
        acc <= {acc[ACC_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/gbr_merge.sv
module gbr_merge import gbr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [LANES-1:0][CHAN_W-1:0] lane_q,
  input  logic                         last,
  output logic                         free,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [PIX_W-1:0]             blurred_word,
  output logic                         frame_last
);

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blurred_word <= lane_q;
      frame_last   <= last;
    end
  end

endmodule

FILE: rtl/gaussian_blur_5x5_renormalized.sv
// 5x5 Gaussian blur over a raster stream of A,R,G,B pixels.
// Source channel: src_valid/src_stall with operation and pixel_word. Pixel
// items (operation 0) are written to a ring buffer; drain ticks (operation 1)
// flush the results still owed after the last pixel of a frame.
// Result channel: res_valid/res_stall with blurred_word and frame_last.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 = width, 1 = height;
// a write restarts the frame. Write only while the block is idle.
// Result k leaves once pixel k + 2*width + 2 is in (or on a drain tick).
// A pixel that causes no result is written and the block stays idle. One
// that causes a result passes through the accept cycle, 25 tap reads from
// the ring (one per cycle), a step to finish accumulating, restoring
// division in the four channel lanes, and the output register load, which
// waits for a free register; res_valid rises in the cycle after the load.
// While res_stall holds, the output register holds its result; a new item
// is still accepted and its result waits in the lanes until the register
// frees. Reset sets width 640, height 480 and empties the frame; the ring
// needs no clearing since its data is only used where it has been written.
`include "gaussian_blur_5x5_renormalized_defines.svh"
module gaussian_blur_5x5_renormalized import gbr_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  logic                  operation,
  input  logic [PIX_W-1:0]      pixel_word,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [PIX_W-1:0]      blurred_word,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(4 * MAX_WIDTH + 8);

  gbr_state_t state, state_next;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [CNT_W-1:0]   items_seen;
  logic [CNT_W-1:0]   results_sent;
  logic [IMG_W_W-1:0] ox;
  logic [IMG_H_W-1:0] oy;

  logic [IMG_W_W-1:0] w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [CNT_W-1:0]   total;
  logic [CNT_W:0]     need_raw;
  logic [CNT_W:0]     need;
  logic [CNT_W-1:0]   items_inc;
  logic [CNT_W-1:0]   results_inc;
  logic               accept;
  logic               pix_ok;
  logic               start;
  logic               last_result;

  logic [TAP_W-1:0]   dy;
  logic [TAP_W-1:0]   dx;
  logic [AW-1:0]      addr;
  logic [IMG_H_W:0]   ry;
  logic [IMG_W_W:0]   cx;
  logic               in_img;
  logic               tap_last;
  logic               tap_valid;
  logic [WT_W-1:0]    tap_wt;
  logic [PIX_W-1:0]   rd_data;
  logic [WSUM_W-1:0]  wsum;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [PIX_W-1:0]   ring [2**AW];

  lane_ctl_t                    lane_ctl;
  logic [LANES-1:0][CHAN_W-1:0] lane_q;
  logic                         load;
  logic                         merge_free;

  always_comb begin
    w_eff = image_width;
    if (image_width == '0) begin
      w_eff = IMG_W_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = IMG_W_W'(MAX_WIDTH);
    end
    h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;
  end

  assign total       = CNT_W'(w_eff) * CNT_W'(h_eff);
  assign need_raw    = (CNT_W+1)'(results_sent) + (CNT_W+1)'({w_eff, 1'b0})
                       + (CNT_W+1)'(3);
  assign need        = (need_raw > (CNT_W+1)'(total)) ? (CNT_W+1)'(total) : need_raw;
  assign items_inc   = items_seen + CNT_W'(1);
  assign results_inc = results_sent + CNT_W'(1);
  assign last_result = (results_inc >= total);

  assign src_stall = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = src_valid && !src_stall;
  assign pix_ok    = accept && (operation == OP_PIXEL) && (items_seen < total);
  assign start     = accept && (results_sent < total) &&
                     ((operation == OP_PIXEL && items_seen < total &&
                       (CNT_W+1)'(items_inc) >= need) ||
                      (operation == OP_DRAIN && items_seen >= total));

  assign ry       = (IMG_H_W+1)'(oy) + (IMG_H_W+1)'(dy);
  assign cx       = (IMG_W_W+1)'(ox) + (IMG_W_W+1)'(dx);
  assign in_img   = (ry >= (IMG_H_W+1)'(2)) && (ry < (IMG_H_W+1)'(h_eff) + (IMG_H_W+1)'(2)) &&
                    (cx >= (IMG_W_W+1)'(2)) && (cx < (IMG_W_W+1)'(w_eff) + (IMG_W_W+1)'(2));
  assign tap_last = (dy == TAP_LAST) && (dx == TAP_LAST);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_TAPS;
      ST_TAPS:   if (tap_last) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE:   if (merge_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl.clear      = 1'b0;
    lane_ctl.accumulate = tap_valid;
    lane_ctl.div_step   = 1'b0;
    load                = 1'b0;
    case (state)
      ST_IDLE:   lane_ctl.clear = start;
      ST_DIVIDE: lane_ctl.div_step = 1'b1;
      ST_DONE:   load = merge_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      image_width  <= IMG_W_RESET;
      image_height <= IMG_H_RESET;
      items_seen   <= '0;
      results_sent <= '0;
      ox           <= '0;
      oy           <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          image_width <= cfg_data[IMG_W_W-1:0];
        end else begin
          image_height <= cfg_data[IMG_H_W-1:0];
        end
        items_seen   <= '0;
        results_sent <= '0;
        ox           <= '0;
        oy           <= '0;
      end else begin
        if (pix_ok) begin
          items_seen <= items_inc;
        end
        if (load) begin
          if (last_result) begin
            items_seen   <= '0;
            results_sent <= '0;
            ox           <= '0;
            oy           <= '0;
          end else begin
            results_sent <= results_inc;
            if (ox + IMG_W_W'(1) == w_eff) begin
              ox <= '0;
              oy <= oy + IMG_H_W'(1);
            end else begin
              ox <= ox + IMG_W_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else begin
      tap_valid <= (state == ST_TAPS) && in_img;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dy   <= '0;
      dx   <= '0;
      addr <= AW'(results_sent) - AW'({w_eff, 1'b0}) - AW'(2);
    end else if (state == ST_TAPS) begin
      if (dx == TAP_LAST) begin
        dx   <= '0;
        dy   <= dy + TAP_W'(1);
        addr <= addr + AW'(w_eff) - AW'(4);
      end else begin
        dx   <= dx + TAP_W'(1);
        addr <= addr + AW'(1);
      end
    end
    tap_wt <= kernel_weight(dy, dx);
    if (lane_ctl.clear) begin
      wsum <= '0;
    end else if (tap_valid) begin
      wsum <= wsum + WSUM_W'(tap_wt);
    end
    if (state == ST_DIVIDE) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end else begin
      div_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ok) begin
      ring[items_seen[AW-1:0]] <= pixel_word;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= ring[addr];
  end

  for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
    gbr_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .weight   (tap_wt),
      .sample   (rd_data[ch*CHAN_W +: CHAN_W]),
      .wsum     (wsum),
      .quotient (lane_q[ch])
    );
  end

  gbr_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .lane_q       (lane_q),
    .last         (last_result),
    .free         (merge_free),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .blurred_word (blurred_word),
    .frame_last   (frame_last)
  );

  `GBR_ASSERT(a_results_behind, clk, rst, results_sent <= items_seen)
  `GBR_ASSERT(a_items_in_frame, clk, rst, items_seen <= total)
  `GBR_ASSERT(a_center_weight, clk, rst, state != ST_DIVIDE || wsum >= CENTER_WEIGHT)
  `GBR_ASSERT_NEXT(a_load_shows, clk, rst, state == ST_DONE && merge_free, res_valid)

endmodule
